[design/nfrsa_pkg.sv]
// Package: constants and state type of the nearest free run slot allocator.
`default_nettype none
package nfrsa_pkg;
  localparam int NUM_SLOTS = 1440;
  localparam int SLOT_W    = 11;
  localparam int LEN_W     = 12;
  localparam int GAP_W     = 8;
  localparam int EXT_W     = 13;
  localparam int WORD_W    = 32;
  localparam int WB        = $clog2(WORD_W);
  localparam int DEPTH     = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(15);

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_DRD  = 11'b00000000100,
    S_DCK  = 11'b00000001000,
    S_BRD  = 11'b00000010000,
    S_BCK  = 11'b00000100000,
    S_FRD  = 11'b00001000000,
    S_FCK  = 11'b00010000000,
    S_SEL  = 11'b00100000000,
    S_MRD  = 11'b01000000000,
    S_MWR  = 11'b10000000000
  } state_t;
endpackage
`default_nettype wire

[design/nfrsa_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module nfrsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[design/nearest_free_run_slot_allocator.sv]
// Top level: nearest free run slot allocator.
// Usage:
//   Request channel: drive req_start and req_length with start high; the
//   request is taken at a rising edge where busy is low.
//   Configuration: gap_we with gap_slots writes the gap register (reset 15);
//   write only while idle.
//   Result channel: done is high for one cycle with placed, granted_start and
//   moved. The receiver cannot stall; results must be taken when shown.
// Operation: a request with zero effective length answers with done in the
//   cycle after it is taken. Otherwise the slot map is probed one slot at a
//   time through the single RAM port, each probe a read state then a check
//   state: the direct check, then the backward and forward scans if needed,
//   then a read-modify-write of the map for each reserved slot. One request
//   is handled at a time.
// Reset: rst clears control and then sweeps all DEPTH (45) words of the map
//   RAM to all free, one word per cycle, with busy high.
`default_nettype none
module nearest_free_run_slot_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [nfrsa_pkg::SLOT_W-1:0]  req_start,
  input  wire logic [nfrsa_pkg::SLOT_W-1:0]  req_length,
  input  wire logic                          gap_we,
  input  wire logic [nfrsa_pkg::GAP_W-1:0]   gap_slots,
  output logic                               done,
  output logic                               placed,
  output logic [nfrsa_pkg::SLOT_W-1:0]       granted_start,
  output logic                               moved
);
  import nfrsa_pkg::*;

  localparam logic [EXT_W-1:0] N_EXT   = EXT_W'(NUM_SLOTS);
  localparam logic [EXT_W-1:0] LAST    = EXT_W'(NUM_SLOTS - 1);
  localparam logic [AW-1:0]    LAST_WD = AW'(DEPTH - 1);

  state_t            state;
  logic [GAP_W-1:0]  gap;
  logic [EXT_W-1:0]  s, i, back, fwd, mend, grant;
  logic [LEN_W-1:0]  e, run;
  logic              bfound, ffound;
  logic [AW-1:0]     clr_addr;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic              bit_free;
  logic [LEN_W-1:0]  run_inc;
  logic [LEN_W-1:0]  e_in;
  logic [EXT_W-1:0]  s_in, se, start_back, mend_raw;

  assign e_in       = LEN_W'(req_length) + LEN_W'(gap);
  assign s_in       = EXT_W'(req_start);
  assign se         = s + EXT_W'(e);
  assign start_back = (s > LAST) ? LAST : s;
  assign bit_free   = !ram_rdata[i[WB-1:0]];
  assign run_inc    = run + LEN_W'(1);
  assign busy       = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | (WORD_W'(1) << i[WB-1:0]);
    ram_addr  = AW'(i >> WB);
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_MWR: ram_we = 1'b1;
      default: ;
    endcase
  end

  nfrsa_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  logic [EXT_W-1:0] grant_sel;
  logic             any_found;
  always_comb begin
    any_found = bfound || ffound;
    if (bfound && ffound) begin
      grant_sel = ((s - back) > (fwd - s)) ? fwd : back;
    end else if (bfound) begin
      grant_sel = back;
    end else begin
      grant_sel = fwd;
    end
    mend_raw = grant_sel + EXT_W'(e) + EXT_W'(gap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      gap      <= GAP_RESET;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (gap_we) begin
        gap <= gap_slots;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_WD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            s      <= s_in;
            e      <= e_in;
            run    <= '0;
            bfound <= 1'b0;
            ffound <= 1'b0;
            if (e_in == '0) begin
              done          <= 1'b1;
              placed        <= (s_in < N_EXT);
              granted_start <= (s_in < N_EXT) ? req_start : '0;
              moved         <= 1'b0;
            end else if (s_in + EXT_W'(e_in) <= N_EXT) begin
              i     <= s_in;
              state <= S_DRD;
            end else begin
              i     <= (s_in > LAST) ? LAST : s_in;
              state <= S_BRD;
            end
          end
        end
        S_DRD: state <= S_DCK;
        S_DCK: begin
          if (!bit_free) begin
            i     <= start_back;
            run   <= '0;
            state <= S_BRD;
          end else if (i == se - EXT_W'(1)) begin
            i     <= s;
            grant <= s;
            mend  <= ((se + EXT_W'(gap)) > N_EXT) ? N_EXT : se + EXT_W'(gap);
            state <= S_MRD;
          end else begin
            i     <= i + EXT_W'(1);
            state <= S_DRD;
          end
        end
        S_BRD: state <= S_BCK;
        S_BCK: begin
          if (bit_free && run_inc == e) begin
            back   <= i;
            bfound <= 1'b1;
          end
          if ((bit_free && run_inc == e) || i == '0) begin
            run <= '0;
            i   <= se;
            state <= (se < N_EXT) ? S_FRD : S_SEL;
          end else begin
            run   <= bit_free ? run_inc : '0;
            i     <= i - EXT_W'(1);
            state <= S_BRD;
          end
        end
        S_FRD: state <= S_FCK;
        S_FCK: begin
          if (bit_free && run_inc == e) begin
            fwd    <= i - EXT_W'(e) + EXT_W'(1);
            ffound <= 1'b1;
            state  <= S_SEL;
          end else if (i == LAST) begin
            state <= S_SEL;
          end else begin
            run   <= bit_free ? run_inc : '0;
            i     <= i + EXT_W'(1);
            state <= S_FRD;
          end
        end
        S_SEL: begin
          if (any_found) begin
            i     <= grant_sel;
            grant <= grant_sel;
            mend  <= (mend_raw > N_EXT) ? N_EXT : mend_raw;
            state <= S_MRD;
          end else begin
            done          <= 1'b1;
            placed        <= 1'b0;
            granted_start <= '0;
            moved         <= 1'b0;
            state         <= S_IDLE;
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (i + EXT_W'(1) == mend) begin
            done          <= 1'b1;
            placed        <= 1'b1;
            granted_start <= SLOT_W'(grant);
            moved         <= (grant != s);
            state         <= S_IDLE;
          end else begin
            state <= S_MRD;
          end
          i <= i + EXT_W'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
